FILE: rtl/rtc_pkg.sv
// shared types and constants for the ray/triangle closest-hit block
// no dependencies; imported by rtc_front, rtc_back, ray_triangle_closest_hit, rtc_hit_checker and the testbench top
package rtc_pkg;

    // queue depth between the front and the back
    localparam int Q_DEPTH = 2;

    // largest reportable distance, unsigned Q15.16
    localparam logic [30:0] MAX_DIST = 31'h7FFF_FFFF;

    // 1.0 in Q2.30
    localparam logic signed [31:0] DIR_ONE = 32'sh4000_0000;

    typedef enum logic [2:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5,
        REG_EPSILON  = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] c_x;
        logic signed [31:0] c_y;
        logic signed [31:0] c_z;
        logic               last_triangle;
    } tri_item_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
        logic signed [31:0] hit_z;
        logic [30:0]        hit_distance;
    } hit_item_t;

    // ray as seen by the datapath, direction already clamped
    typedef struct packed {
        logic [2:0][31:0] origin;
        logic [2:0][31:0] dir;
        logic [15:0]      eps;
    } ray_t;

    // triangle prepared by the front: edges and origin offset
    typedef struct packed {
        logic [2:0][32:0] e1;
        logic [2:0][32:0] e2;
        logic [2:0][32:0] s;
        logic             last;
    } prep_t;

    // queue head as presented to the back
    typedef struct packed {
        logic  avail;
        prep_t item;
    } q_head_t;

    function automatic logic [31:0] dir_clamp(input logic [31:0] v);
        logic signed [31:0] sv;
        sv = $signed(v);
        if (sv > DIR_ONE) begin
            return DIR_ONE;
        end
        if (sv < -DIR_ONE) begin
            return -DIR_ONE;
        end
        return v;
    endfunction

endpackage

FILE: rtl/rtc_front.sv
// front part: accepts triangles, forms edge vectors and origin offset,
// and holds them in a short queue for the back; uses rtc_pkg
module rtc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rtc_pkg::tri_item_t in_item,
    input  logic [2:0][31:0]   origin,
    input  logic               pop,
    output rtc_pkg::q_head_t   head
);
    import rtc_pkg::*;

    prep_t      mem_reg [0:Q_DEPTH-1];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    prep_t      prep;

    assign in_stall = (cnt_reg == 2'(Q_DEPTH));
    assign push     = in_valid && !in_stall;

    // edge vectors and origin offset relative to the first vertex
    always_comb
    begin
        prep.e1[0] = 33'(in_item.b_x) - 33'(in_item.a_x);
        prep.e1[1] = 33'(in_item.b_y) - 33'(in_item.a_y);
        prep.e1[2] = 33'(in_item.b_z) - 33'(in_item.a_z);
        prep.e2[0] = 33'(in_item.c_x) - 33'(in_item.a_x);
        prep.e2[1] = 33'(in_item.c_y) - 33'(in_item.a_y);
        prep.e2[2] = 33'(in_item.c_z) - 33'(in_item.a_z);
        prep.s[0]  = 33'($signed(origin[0])) - 33'(in_item.a_x);
        prep.s[1]  = 33'($signed(origin[1])) - 33'(in_item.a_y);
        prep.s[2]  = 33'($signed(origin[2])) - 33'(in_item.a_z);
        prep.last  = in_item.last_triangle;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= prep;
        end
    end

    assign head.avail = (cnt_reg != 2'd0);
    assign head.item  = mem_reg[rd_ptr_reg];

endmodule

FILE: rtl/rtc_back.sv
// back part: sequencer with one shared 33x17 multiplier, range tests,
// radix-2 divider, closest-hit tracking and result register; uses rtc_pkg
module rtc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  rtc_pkg::q_head_t   head,
    output logic               pop,
    input  rtc_pkg::ray_t      ray,
    output logic               out_valid,
    input  logic               out_stall,
    output rtc_pkg::hit_item_t out_item
);
    import rtc_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MUL   = 7'b0000010,
        ST_CHK_A = 7'b0000100,
        ST_CHK_B = 7'b0001000,
        ST_DIV   = 7'b0010000,
        ST_QUAL  = 7'b0100000,
        ST_FIN   = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {OPA_DIR, OPA_E1, OPA_E2, OPA_S} opa_t;
    typedef enum logic [2:0] {OPB_E1, OPB_E2, OPB_P, OPB_Q, OPB_DV} opb_t;
    typedef enum logic [2:0] {DST_P, DST_Q, DST_DET, DST_UN, DST_VN, DST_TN, DST_PT} dst_t;

    typedef struct packed {
        opa_t       a;
        logic [1:0] ai;
        opb_t       b;
        logic [1:0] bi;
        logic       neg;
        logic       last;
        dst_t       dst;
        logic [1:0] di;
    } term_t;

    localparam logic [4:0] T_TN_LAST = 5'd23;
    localparam logic [4:0] T_PT_FIRST = 5'd24;
    localparam logic [4:0] T_PT_LAST = 5'd26;
    localparam logic [4:0] DIV_STEPS = 5'd30;
    localparam logic signed [33:0] PT_MAX = 34'sd2147483647;
    localparam logic signed [33:0] PT_MIN = -34'sd2147483648;

    function automatic logic [1:0] nxt(input logic [1:0] k);
        return (k == 2'd2) ? 2'd0 : k + 2'd1;
    endfunction

    // product schedule: six cross terms pairs, four dot products, hit point
    function automatic term_t term_of(input logic [4:0] t);
        term_t      r;
        logic [4:0] off;
        logic [1:0] k;
        r.a    = OPA_DIR;
        r.ai   = 2'd0;
        r.b    = OPB_DV;
        r.bi   = 2'd0;
        r.neg  = 1'b0;
        r.last = 1'b0;
        r.dst  = DST_PT;
        r.di   = 2'd0;
        off    = 5'd0;
        k      = 2'd0;
        if (t < 5'd12)
        begin
            off = {1'b0, t[4:1]};
            if (off < 5'd3)
            begin
                r.a   = OPA_DIR;
                r.b   = OPB_E2;
                r.dst = DST_P;
            end
            else
            begin
                off   = off - 5'd3;
                r.a   = OPA_S;
                r.b   = OPB_E1;
                r.dst = DST_Q;
            end
            k    = off[1:0];
            r.di = k;
            if (!t[0])
            begin
                r.ai = nxt(k);
                r.bi = nxt(nxt(k));
            end
            else
            begin
                r.ai   = nxt(nxt(k));
                r.bi   = nxt(k);
                r.neg  = 1'b1;
                r.last = 1'b1;
            end
        end
        else if (t < 5'd15)
        begin
            off    = t - 5'd12;
            k      = off[1:0];
            r.a    = OPA_E1;
            r.b    = OPB_P;
            r.ai   = k;
            r.bi   = k;
            r.last = (k == 2'd2);
            r.dst  = DST_DET;
        end
        else if (t < 5'd18)
        begin
            off    = t - 5'd15;
            k      = off[1:0];
            r.a    = OPA_S;
            r.b    = OPB_P;
            r.ai   = k;
            r.bi   = k;
            r.last = (k == 2'd2);
            r.dst  = DST_UN;
        end
        else if (t < 5'd21)
        begin
            off    = t - 5'd18;
            k      = off[1:0];
            r.a    = OPA_DIR;
            r.b    = OPB_Q;
            r.ai   = k;
            r.bi   = k;
            r.last = (k == 2'd2);
            r.dst  = DST_VN;
        end
        else if (t < T_PT_FIRST)
        begin
            off    = t - 5'd21;
            k      = off[1:0];
            r.a    = OPA_E2;
            r.b    = OPB_Q;
            r.ai   = k;
            r.bi   = k;
            r.last = (k == 2'd2);
            r.dst  = DST_TN;
        end
        else
        begin
            off    = t - T_PT_FIRST;
            k      = off[1:0];
            r.a    = OPA_DIR;
            r.b    = OPB_DV;
            r.ai   = k;
            r.last = 1'b1;
            r.dst  = DST_PT;
            r.di   = k;
        end
        return r;
    endfunction

    state_t             state_reg, state_next;
    logic [4:0]         t_reg, t_next;
    logic [1:0]         c_reg, c_next;
    logic signed [87:0] sum_reg, sum_next;
    logic signed [32:0] e1_reg [0:2];
    logic signed [32:0] e1_next [0:2];
    logic signed [32:0] e2_reg [0:2];
    logic signed [32:0] e2_next [0:2];
    logic signed [32:0] s_reg [0:2];
    logic signed [32:0] s_next [0:2];
    logic signed [35:0] p_reg [0:2];
    logic signed [35:0] p_next [0:2];
    logic signed [50:0] q_reg [0:2];
    logic signed [50:0] q_next [0:2];
    logic signed [87:0] det_reg, det_next;
    logic signed [87:0] un_reg, un_next;
    logic signed [87:0] vn_reg, vn_next;
    logic signed [87:0] tn_reg, tn_next;
    logic [103:0]       rem_reg, rem_next;
    logic [103:0]       dsh_reg, dsh_next;
    logic [30:0]        quo_reg, quo_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               last_reg, last_next;
    logic               found_reg, found_next;
    logic [30:0]        best_reg, best_next;
    logic signed [31:0] bpt_reg [0:2];
    logic signed [31:0] bpt_next [0:2];
    logic               out_valid_reg, out_valid_next;
    hit_item_t          out_reg, out_next;

    term_t              tm;
    logic signed [32:0] opa;
    logic signed [51:0] opb;
    logic [32:0]        a_mag;
    logic [50:0]        b_mag;
    logic [16:0]        chunk;
    logic [49:0]        pp;
    logic [84:0]        pp_sh;
    logic               neg;
    logic signed [87:0] term_v;
    logic signed [87:0] sum_nx;
    logic signed [87:0] sh30;
    logic signed [87:0] sh16;
    logic signed [87:0] sh14;
    logic signed [33:0] pt_sum;
    logic signed [31:0] pt_sat;
    logic signed [87:0] lim;
    logic               rej_a;
    logic               rej_b;
    logic [103:0]       num;
    logic [103:0]       dlim;
    logic               div_ge;
    logic               can_load;

    assign tm = term_of(t_reg);

    // operand selection
    always_comb
    begin
        case (tm.a)
            OPA_DIR: opa = 33'($signed(ray.dir[tm.ai]));
            OPA_E1:  opa = e1_reg[tm.ai];
            OPA_E2:  opa = e2_reg[tm.ai];
            OPA_S:   opa = s_reg[tm.ai];
            default: opa = '0;
        endcase
        case (tm.b)
            OPB_E1:  opb = 52'(e1_reg[tm.bi]);
            OPB_E2:  opb = 52'(e2_reg[tm.bi]);
            OPB_P:   opb = 52'(p_reg[tm.bi]);
            OPB_Q:   opb = 52'(q_reg[tm.bi]);
            OPB_DV:  opb = $signed({21'd0, quo_reg});
            default: opb = '0;
        endcase
    end

    // sign-magnitude multiply, 17 bits of the second operand per cycle
    always_comb
    begin
        a_mag = opa[32] ? 33'(-opa) : 33'(opa);
        b_mag = opb[51] ? 51'(-opb) : 51'(opb);
        case (c_reg)
            2'd0:    chunk = b_mag[16:0];
            2'd1:    chunk = b_mag[33:17];
            default: chunk = b_mag[50:34];
        endcase
        pp = a_mag * chunk;
        case (c_reg)
            2'd0:    pp_sh = 85'(pp);
            2'd1:    pp_sh = 85'(pp) << 17;
            default: pp_sh = 85'(pp) << 34;
        endcase
        neg    = opa[32] ^ opb[51] ^ tm.neg;
        term_v = neg ? -$signed({3'b000, pp_sh}) : $signed({3'b000, pp_sh});
        sum_nx = sum_reg + term_v;
        sh30   = sum_nx >>> 30;
        sh16   = sum_nx >>> 16;
        sh14   = sum_nx >>> 14;
        pt_sum = 34'(sh30) + 34'($signed(ray.origin[tm.di]));
        if (pt_sum > PT_MAX)
        begin
            pt_sat = PT_MAX[31:0];
        end
        else if (pt_sum < PT_MIN)
        begin
            pt_sat = PT_MIN[31:0];
        end
        else
        begin
            pt_sat = pt_sum[31:0];
        end
    end

    // range tests and divider operands
    always_comb
    begin
        lim    = $signed({56'd0, ray.eps, 16'd0});
        rej_a  = (det_reg == 88'sd0) || ((det_reg < lim) && (det_reg > -lim));
        rej_b  = (un_reg < 0) || (un_reg > det_reg) || (vn_reg < 0) ||
                 ((un_reg + vn_reg) > det_reg) || (tn_reg <= 0);
        num    = 104'(tn_reg) << 16;
        dlim   = 104'(det_reg) << 31;
        div_ge = (rem_reg >= dsh_reg);
    end

    assign can_load = !out_valid_reg || !out_stall;
    assign pop      = (state_reg == ST_IDLE) && head.avail;

    always_comb
    begin
        state_next     = state_reg;
        t_next         = t_reg;
        c_next         = c_reg;
        sum_next       = sum_reg;
        e1_next        = e1_reg;
        e2_next        = e2_reg;
        s_next         = s_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        det_next       = det_reg;
        un_next        = un_reg;
        vn_next        = vn_reg;
        tn_next        = tn_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        bpt_next       = bpt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (head.avail)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        e1_next[k] = $signed(head.item.e1[k]);
                        e2_next[k] = $signed(head.item.e2[k]);
                        s_next[k]  = $signed(head.item.s[k]);
                    end
                    last_next  = head.item.last;
                    t_next     = 5'd0;
                    c_next     = 2'd0;
                    sum_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                sum_next = sum_nx;
                c_next   = c_reg + 2'd1;
                if (c_reg == 2'd2)
                begin
                    c_next = 2'd0;
                    t_next = t_reg + 5'd1;
                    if (tm.last)
                    begin
                        sum_next = '0;
                        case (tm.dst)
                            DST_P:   p_next[tm.di] = sh30[35:0];
                            DST_Q:   q_next[tm.di] = sh16[50:0];
                            DST_DET: det_next = sum_nx;
                            DST_UN:  un_next = sum_nx;
                            DST_VN:  vn_next = sh14;
                            DST_TN:  tn_next = sum_nx;
                            DST_PT:  bpt_next[tm.di] = pt_sat;
                            default: sum_next = '0;
                        endcase
                        if (t_reg == T_TN_LAST)
                        begin
                            state_next = ST_CHK_A;
                        end
                        else if (t_reg == T_PT_LAST)
                        begin
                            state_next = ST_FIN;
                        end
                    end
                end
            end
            ST_CHK_A:
            begin
                // near-zero determinant, then fold the sign into all four
                if (rej_a)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    if (det_reg[87])
                    begin
                        det_next = -det_reg;
                        un_next  = -un_reg;
                        vn_next  = -vn_reg;
                        tn_next  = -tn_reg;
                    end
                    state_next = ST_CHK_B;
                end
            end
            ST_CHK_B:
            begin
                if (rej_b)
                begin
                    state_next = ST_FIN;
                end
                else if (num >= dlim)
                begin
                    quo_next   = MAX_DIST;
                    state_next = ST_QUAL;
                end
                else
                begin
                    rem_next   = num;
                    dsh_next   = 104'(det_reg) << 30;
                    quo_next   = '0;
                    cnt_next   = DIV_STEPS;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_ge)
                begin
                    rem_next = rem_reg - dsh_reg;
                end
                quo_next = {quo_reg[29:0], div_ge};
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    state_next = ST_QUAL;
                end
            end
            ST_QUAL:
            begin
                if ((quo_reg <= {15'd0, ray.eps}) || (found_reg && (quo_reg >= best_reg)))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    found_next = 1'b1;
                    best_next  = quo_reg;
                    t_next     = T_PT_FIRST;
                    c_next     = 2'd0;
                    sum_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_FIN:
            begin
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (can_load)
                begin
                    out_valid_next        = 1'b1;
                    out_next.hit          = found_reg;
                    out_next.hit_x        = found_reg ? bpt_reg[0] : 32'sd0;
                    out_next.hit_y        = found_reg ? bpt_reg[1] : 32'sd0;
                    out_next.hit_z        = found_reg ? bpt_reg[2] : 32'sd0;
                    out_next.hit_distance = found_reg ? best_reg : 31'd0;
                    found_next            = 1'b0;
                    best_next             = MAX_DIST;
                    for (int k = 0; k < 3; k++)
                    begin
                        bpt_next[k] = 32'sd0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            found_reg     <= 1'b0;
            best_reg      <= MAX_DIST;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                bpt_reg[k] <= 32'sd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            found_reg     <= found_next;
            best_reg      <= best_next;
            out_valid_reg <= out_valid_next;
            bpt_reg       <= bpt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg    <= t_next;
        c_reg    <= c_next;
        sum_reg  <= sum_next;
        e1_reg   <= e1_next;
        e2_reg   <= e2_next;
        s_reg    <= s_next;
        p_reg    <= p_next;
        q_reg    <= q_next;
        det_reg  <= det_next;
        un_reg   <= un_next;
        vn_reg   <= vn_next;
        tn_reg   <= tn_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
        last_reg <= last_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

FILE: rtl/ray_triangle_closest_hit.sv
// the back works on one triangle at a time, with the shared 33x17
// multiplier (up to 27 products) and the 31-step radix-2 divider, while
// the queue holds up to two more triangles
// reset: ray origin 0, direction (0, 0, -1), epsilon 1 lsb, no hit held,
// queue and result register empty; uses rtc_pkg, rtc_front and rtc_back
module ray_triangle_closest_hit (
    input  logic               clk,
    input  logic               rst_n,
    // triangle channel
    input  logic               in_valid,
    output logic               in_stall,
    input  rtc_pkg::tri_item_t in_item,
    // result channel, one transfer per triangle set
    output logic               out_valid,
    input  logic               out_stall,
    output rtc_pkg::hit_item_t out_item,
    // configuration write port
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import rtc_pkg::*;

    logic [2:0][31:0] origin_reg;
    logic [2:0][31:0] dir_reg;
    logic [15:0]      eps_reg;
    ray_t             ray;
    logic             pop;
    q_head_t          head;

    // configuration registers, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg <= '0;
            dir_reg    <= {(-DIR_ONE), 32'd0, 32'd0};
            eps_reg    <= 16'd1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ORIGIN_X: origin_reg[0] <= cfg_data;
                REG_ORIGIN_Y: origin_reg[1] <= cfg_data;
                REG_ORIGIN_Z: origin_reg[2] <= cfg_data;
                REG_DIR_X:    dir_reg[0] <= cfg_data;
                REG_DIR_Y:    dir_reg[1] <= cfg_data;
                REG_DIR_Z:    dir_reg[2] <= cfg_data;
                REG_EPSILON:  eps_reg <= cfg_data[15:0];
                default:      eps_reg <= eps_reg;
            endcase
        end
    end

    // direction is clamped to +-1.0 before any use
    always_comb
    begin
        ray.origin = origin_reg;
        for (int k = 0; k < 3; k++)
        begin
            ray.dir[k] = dir_clamp(dir_reg[k]);
        end
        ray.eps = eps_reg;
    end

    // front: input transfer, edge setup and queue
    rtc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .origin   (origin_reg),
        .pop      (pop),
        .head     (head)
    );

    // back: products, tests, division, closest-hit state and result register
    rtc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .ray       (ray),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

FILE: tb/sv/rtc_hit_checker.sv
// closest-hit checker: watches the triangle, result and register channels,
// predicts every result in fixed point and compares it field by field
// depends on rtc_pkg for the item structs and register indexes
module rtc_hit_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  rtc_pkg::tri_item_t in_item,
    input  logic               out_valid,
    input  logic               out_stall,
    input  rtc_pkg::hit_item_t out_item,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 fail_count,
    output int                 pending
);
    import rtc_pkg::*;

    typedef logic signed [127:0] wide_t;

    // shadow of the ray registers
    logic signed [31:0] ray_o [3];
    logic signed [31:0] ray_d [3];
    logic [15:0]        ray_eps;

    // nearest hit so far in the current set
    logic [30:0]        near_dist;
    logic               near_found;
    logic signed [31:0] near_pt [3];

    hit_item_t hits_due [$];

    assign pending = hits_due.size();

    function automatic wide_t wx(input logic signed [31:0] v);
        return v;
    endfunction

    function automatic wide_t clamp_dir(input logic signed [31:0] v);
        wide_t r;
        r = wx(v);
        if (r > wx(DIR_ONE))
        begin
            r = wx(DIR_ONE);
        end
        if (r < -wx(DIR_ONE))
        begin
            r = -wx(DIR_ONE);
        end
        return r;
    endfunction

    // one triangle against the ray, updates the nearest hit
    task automatic test_triangle(input tri_item_t t);
        wide_t o [3], d [3], a [3], e1 [3], e2 [3], s [3], p [3], q [3];
        wide_t det, un, vn, tn, lim, quot, v;
        logic [30:0] dv;
        int i, j;
        a[0] = wx(t.a_x); a[1] = wx(t.a_y); a[2] = wx(t.a_z);
        e1[0] = wx(t.b_x) - a[0]; e1[1] = wx(t.b_y) - a[1]; e1[2] = wx(t.b_z) - a[2];
        e2[0] = wx(t.c_x) - a[0]; e2[1] = wx(t.c_y) - a[1]; e2[2] = wx(t.c_z) - a[2];
        for (int k = 0; k < 3; k++)
        begin
            o[k] = wx(ray_o[k]);
            d[k] = clamp_dir(ray_d[k]);
            s[k] = o[k] - a[k];
        end
        for (int k = 0; k < 3; k++)
        begin
            i = (k + 1) % 3;
            j = (k + 2) % 3;
            p[k] = (d[i] * e2[j] - d[j] * e2[i]) >>> 30;
            q[k] = (s[i] * e1[j] - s[j] * e1[i]) >>> 16;
        end
        det = e1[0] * p[0] + e1[1] * p[1] + e1[2] * p[2];
        un  = s[0] * p[0] + s[1] * p[1] + s[2] * p[2];
        vn  = (d[0] * q[0] + d[1] * q[1] + d[2] * q[2]) >>> 14;
        tn  = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
        lim = $signed({96'd0, ray_eps, 16'd0});
        if (det == 0)
        begin
            return;
        end
        if (det < lim && -lim < det)
        begin
            return;
        end
        if (det < 0)
        begin
            det = -det; un = -un; vn = -vn; tn = -tn;
        end
        if (un < 0 || un > det || vn < 0 || un + vn > det || tn <= 0)
        begin
            return;
        end
        quot = (tn <<< 16) / det;
        dv = (quot > wide_t'(MAX_DIST)) ? MAX_DIST : quot[30:0];
        if ({1'b0, dv} <= {16'd0, ray_eps})
        begin
            return;
        end
        if (near_found && dv >= near_dist)
        begin
            return;
        end
        near_found = 1'b1;
        near_dist  = dv;
        for (int k = 0; k < 3; k++)
        begin
            v = o[k] + ((d[k] * $signed({97'd0, dv})) >>> 30);
            if (v > wx(32'sh7FFF_FFFF))
            begin
                v = wx(32'sh7FFF_FFFF);
            end
            if (v < wx(32'sh8000_0000))
            begin
                v = wx(32'sh8000_0000);
            end
            near_pt[k] = v[31:0];
        end
    endtask

    task automatic report_miss(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        $display("checker: %s got %h want %h", what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        hit_item_t want;
        if (!rst_n)
        begin
            ray_o[0] = 0; ray_o[1] = 0; ray_o[2] = 0;
            ray_d[0] = 0; ray_d[1] = 0; ray_d[2] = -DIR_ONE;
            ray_eps    = 16'd1;
            near_dist  = MAX_DIST;
            near_found = 1'b0;
            near_pt[0] = 0; near_pt[1] = 0; near_pt[2] = 0;
            hits_due.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_ORIGIN_X: ray_o[0] = cfg_data;
                    REG_ORIGIN_Y: ray_o[1] = cfg_data;
                    REG_ORIGIN_Z: ray_o[2] = cfg_data;
                    REG_DIR_X:    ray_d[0] = cfg_data;
                    REG_DIR_Y:    ray_d[1] = cfg_data;
                    REG_DIR_Z:    ray_d[2] = cfg_data;
                    REG_EPSILON:  ray_eps  = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                test_triangle(in_item);
                if (in_item.last_triangle)
                begin
                    want.hit          = near_found;
                    want.hit_x        = near_found ? near_pt[0] : 32'd0;
                    want.hit_y        = near_found ? near_pt[1] : 32'd0;
                    want.hit_z        = near_found ? near_pt[2] : 32'd0;
                    want.hit_distance = near_found ? near_dist : 31'd0;
                    hits_due.push_back(want);
                    near_dist  = MAX_DIST;
                    near_found = 1'b0;
                    near_pt[0] = 0; near_pt[1] = 0; near_pt[2] = 0;
                end
            end
            if (out_valid && !out_stall)
            begin
                if (hits_due.size() == 0)
                begin
                    $display("checker: result transfer with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = hits_due.pop_front();
                    if (out_item.hit !== want.hit)
                        report_miss("hit", 32'(out_item.hit), 32'(want.hit));
                    if (out_item.hit_x !== want.hit_x)
                        report_miss("hit_x", out_item.hit_x, want.hit_x);
                    if (out_item.hit_y !== want.hit_y)
                        report_miss("hit_y", out_item.hit_y, want.hit_y);
                    if (out_item.hit_z !== want.hit_z)
                        report_miss("hit_z", out_item.hit_z, want.hit_z);
                    if (out_item.hit_distance !== want.hit_distance)
                        report_miss("hit_distance", 32'(out_item.hit_distance),
                                    32'(want.hit_distance));
                end
            end
        end
    end

endmodule

FILE: tb/sv/tb_ray_triangle_closest_hit.sv
// testbench top for ray_triangle_closest_hit: clock, reset, triangle and
// register stimulus, random stalls; rtc_hit_checker predicts and compares
// depends on rtc_pkg, ray_triangle_closest_hit and rtc_hit_checker
module tb_ray_triangle_closest_hit;
    import rtc_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    // queue of two plus one in flight
    localparam int DRAIN_CYCLES = 400;
    localparam int ONE = 65536;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    tri_item_t in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    hit_item_t out_item;
    logic      cfg_write = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    int fail_count;
    int pending;
    int cycles = 0;
    // no idling on either side while set
    bit quiet = 1'b0;

    // ray as last written, for aiming triangles
    logic signed [31:0] aim_o [3];
    logic signed [31:0] aim_d [3];

    always #4 clk = ~clk;

    ray_triangle_closest_hit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rtc_hit_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("ray_triangle_closest_hit: mismatch");
            $finish;
        end
    end

    // result side stalls at random, except in the quiet stretch
    always @(posedge clk)
    begin
        out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 23);
    end

    // one triangle transfer, then maybe a gap with valid low
    task automatic push_triangle(input tri_item_t t);
        logic stalled;
        in_item  <= t;
        in_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end
        while (stalled);
        if (!quiet && $urandom_range(99) < 23)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // register writes happen only with the triangle side idle
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        in_valid  <= 1'b0;
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_ORIGIN_X: aim_o[0] = val;
            REG_ORIGIN_Y: aim_o[1] = val;
            REG_ORIGIN_Z: aim_o[2] = val;
            REG_DIR_X:    aim_d[0] = val;
            REG_DIR_Y:    aim_d[1] = val;
            REG_DIR_Z:    aim_d[2] = val;
            default: ;
        endcase
    endtask

    // wait for all results, then let non-last triangles finish too
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] rnd32();
        return $urandom;
    endfunction

    // triangle scattered around a point on the ray, hits often
    function automatic tri_item_t make_aimed(input bit last);
        tri_item_t t;
        logic signed [63:0] span, off, ctr [3];
        logic signed [31:0] v [9];
        int r;
        span = $urandom_range(ONE / 4, 300 * ONE);
        r = $urandom_range(1 << 10, 1 << 21);
        for (int k = 0; k < 3; k++)
        begin
            off = (64'(aim_d[k]) * span) >>> 30;
            ctr[k] = 64'(aim_o[k]) + off;
        end
        for (int n = 0; n < 9; n++)
        begin
            v[n] = ctr[n % 3][31:0] + $signed($urandom_range(0, 2 * r)) - r;
        end
        t.a_x = v[0]; t.a_y = v[1]; t.a_z = v[2];
        t.b_x = v[3]; t.b_y = v[4]; t.b_z = v[5];
        t.c_x = v[6]; t.c_y = v[7]; t.c_z = v[8];
        t.last_triangle = last;
        return t;
    endfunction

    function automatic tri_item_t make_noise(input bit last);
        tri_item_t t;
        t = {rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32(),
             rnd32(), rnd32(), 1'b0};
        t.last_triangle = last;
        return t;
    endfunction

    function automatic tri_item_t make_tri(input int ax, ay, az, bx, by, bz,
                                           cx, cy, cz, input bit last);
        tri_item_t t;
        t.a_x = ax; t.a_y = ay; t.a_z = az;
        t.b_x = bx; t.b_y = by; t.b_z = bz;
        t.c_x = cx; t.c_y = cy; t.c_z = cz;
        t.last_triangle = last;
        return t;
    endfunction

    // random sets, mostly aimed triangles, the last item closes a set
    task automatic random_sets(input int n);
        bit last;
        for (int i = 0; i < n; i++)
        begin
            last = (i == n - 1) || ($urandom_range(5) == 0);
            if ($urandom_range(99) < 75)
                push_triangle(make_aimed(last));
            else
                push_triangle(make_noise(last));
        end
    endtask

    initial
    begin
        aim_o[0] = 0; aim_o[1] = 0; aim_o[2] = 0;
        aim_d[0] = 0; aim_d[1] = 0; aim_d[2] = -DIR_ONE;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset ray looking down -z
        // plain hit at z = -10
        push_triangle(make_tri(-ONE, -ONE, -10 * ONE, ONE, -ONE, -10 * ONE,
                               0, ONE, -10 * ONE, 1'b1));
        // nearer hit wins over farther, then a miss to the side
        push_triangle(make_tri(-ONE, -ONE, -20 * ONE, ONE, -ONE, -20 * ONE,
                               0, ONE, -20 * ONE, 1'b0));
        push_triangle(make_tri(-ONE, -ONE, -5 * ONE, 0, ONE, -5 * ONE,
                               ONE, -ONE, -5 * ONE, 1'b0));
        push_triangle(make_tri(5 * ONE, 5 * ONE, -3 * ONE, 6 * ONE, 5 * ONE, -3 * ONE,
                               5 * ONE, 6 * ONE, -3 * ONE, 1'b1));
        // degenerate triangle, zero determinant
        push_triangle(make_tri(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, 1'b1));
        // behind the origin
        push_triangle(make_tri(-ONE, -ONE, 4 * ONE, ONE, -ONE, 4 * ONE,
                               0, ONE, 4 * ONE, 1'b1));
        // field extremes
        push_triangle({{9{32'h7FFF_FFFF}}, 1'b0});
        push_triangle({{9{32'h8000_0000}}, 1'b1});
        push_triangle(make_tri(32'h8000_0000, 32'h8000_0000, -ONE,
                               32'h7FFF_FFFF, 32'h8000_0000, -ONE,
                               0, 32'h7FFF_FFFF, -ONE, 1'b1));
        push_triangle({{9{32'h0}}, 1'b1});
        wait_idle();

        // zero epsilon, tiny direction so the distance saturates
        write_reg(REG_EPSILON, 32'd0);
        write_reg(REG_DIR_Z, -32'sd1);
        push_triangle(make_tri(-ONE, -ONE, -10 * ONE, ONE, -ONE, -10 * ONE,
                               0, ONE, -10 * ONE, 1'b1));
        push_triangle(make_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 1'b1));
        wait_idle();

        // direction out of range gets clamped, largest epsilon
        write_reg(REG_DIR_X, 32'h7FFF_FFFF);
        write_reg(REG_DIR_Y, 32'h8000_0000);
        write_reg(REG_DIR_Z, 32'h7FFF_FFFF);
        write_reg(REG_EPSILON, 32'hFFFF_FFFF);
        write_reg(reg_idx_t'(3'd7), 32'h1234_5678);
        random_sets(40);
        wait_idle();

        // random phases with different rays, one without idling
        for (int ph = 0; ph < 8; ph++)
        begin
            quiet = (ph == 3);
            write_reg(REG_ORIGIN_X, (ph == 1) ? 32'h7FFF_0000 : $signed($urandom_range(0, 2000 * ONE)) - 1000 * ONE);
            write_reg(REG_ORIGIN_Y, (ph == 1) ? 32'h8000_0000 : $signed($urandom_range(0, 2000 * ONE)) - 1000 * ONE);
            write_reg(REG_ORIGIN_Z, (ph == 2) ? 32'h7FFF_FFFF : rnd32() >>> 12);
            write_reg(REG_DIR_X, $signed($urandom_range(0, 1 << 31)) - (1 << 30));
            write_reg(REG_DIR_Y, $signed($urandom_range(0, 1 << 31)) - (1 << 30));
            write_reg(REG_DIR_Z, (ph == 4) ? 32'h4000_0000 : (ph == 5) ? 32'hC000_0000
                                 : $signed($urandom_range(0, 1 << 31)) - (1 << 30));
            write_reg(REG_EPSILON, (ph == 6) ? 32'd0 : (ph == 7) ? 32'h0000_FFFF
                                   : $urandom_range(0, 300));
            random_sets(52);
            wait_idle();
        end
        quiet = 1'b0;

        if (fail_count == 0)
        begin
            $display("ray_triangle_closest_hit: match");
        end
        else
        begin
            $display("ray_triangle_closest_hit: mismatch");
        end
        $finish;
    end

endmodule
